FILE: design/ghal_pkg.sv
// Shared types and constants for the generational handle allocator.
// No dependencies.

package ghal_pkg;

  localparam int unsigned SLOT_W = 9;   // handle slot field: slot number plus one
  localparam int unsigned GEN_W  = 32;  // generation field

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CHECK = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_HANDLE = 2'd1,
    STATUS_EXHAUSTED  = 2'd2
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic [SLOT_W-1:0]  handle_slot;
    logic [GEN_W-1:0]   handle_generation;
  } req_t;

  typedef struct packed {
    logic               ok;
    status_e            status;
    logic [SLOT_W-1:0]  out_slot;
    logic [GEN_W-1:0]   out_generation;
    logic [SLOT_W-1:0]  live_count;
  } rsp_t;

endpackage

FILE: design/ghal_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the slot table and the free stack. Depends on nothing.

module ghal_ram #(
  parameter int unsigned Width = 33,
  parameter int unsigned Depth = 256
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // hold read data until the next read is issued
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/generational_handle_allocator.sv
// Top level of the generational handle allocator: control, counters and output register.
// Depends on ghal_pkg and ghal_ram.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------
//   in      | to block  | in_valid_i / in_ready_o | in_item_i  (req_t)
//   out     | from block| out_valid_o/ out_ready_i| out_item_o (rsp_t)
//
// Each item is accepted in ST_IDLE, where the slot table and the free stack are read;
// ST_EXEC then modifies it, writes both memories back and loads the output register.
// The next item is taken once the write-back is done, so reads always see it.
// A stalled output holds the item in the write-back cycle until the register frees.
// Reset clears counters and control only; memory contents stay undefined and
// are never used before being written, so no clearing pass is needed.

module generational_handle_allocator
  import ghal_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_item_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned CmpW = (CntW > SLOT_W) ? CntW : SLOT_W;
  localparam int unsigned SlotEntW = 1 + GEN_W;
  localparam int unsigned StkEntW = IdxW + GEN_W;
  localparam logic [CntW-1:0] SlotsC = CntW'(SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  logic [CntW-1:0] free_depth_q, free_depth_d;
  logic [CntW-1:0] high_water_q, high_water_d;
  logic [CntW-1:0] live_total_q, live_total_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_item_q, out_item_d;

  logic                in_acc;
  logic                exec_done;
  logic [IdxW-1:0]     slot_raddr, stk_raddr;
  logic                slot_we, stk_we;
  logic [IdxW-1:0]     slot_waddr, stk_waddr;
  logic [SlotEntW-1:0] slot_wdata, slot_rdata;
  logic [StkEntW-1:0]  stk_wdata, stk_rdata;

  logic             live_r;
  logic [GEN_W-1:0] gen_r, gen_inc, gen_next;
  logic [CmpW-1:0]  hidx_ext;
  logic             handle_ok;
  logic [IdxW-1:0]  pop_idx;
  logic [GEN_W-1:0] pop_gen;
  rsp_t             rsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign exec_done  = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  // both memories are read on the accept edge
  assign slot_raddr = IdxW'(in_item_i.handle_slot - SLOT_W'(1));
  assign stk_raddr  = IdxW'(free_depth_q - CntW'(1));

  ghal_ram #(
    .Width (SlotEntW),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (in_acc),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // each free stack entry carries the slot index and its current generation
  ghal_ram #(
    .Width (StkEntW),
    .Depth (SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (in_acc),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign live_r   = slot_rdata[GEN_W];
  assign gen_r    = slot_rdata[GEN_W-1:0];
  assign gen_inc  = gen_r + GEN_W'(1);
  assign gen_next = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
  assign hidx_ext = CmpW'(req_q.handle_slot) - CmpW'(1);
  assign pop_idx  = stk_rdata[StkEntW-1:GEN_W];
  assign pop_gen  = stk_rdata[GEN_W-1:0];

  assign handle_ok = (req_q.handle_slot != '0) && (req_q.handle_generation != '0)
                  && (hidx_ext < CmpW'(high_water_q)) && live_r
                  && (gen_r == req_q.handle_generation);

  always_comb begin
    free_depth_d = free_depth_q;
    high_water_d = high_water_q;
    live_total_d = live_total_q;
    slot_we      = 1'b0;
    slot_waddr   = '0;
    slot_wdata   = '0;
    stk_we       = 1'b0;
    stk_waddr    = '0;
    stk_wdata    = '0;
    rsp          = '0;
    rsp.status   = STATUS_OK;

    unique case (req_q.mode)
      MODE_ALLOC: begin
        if (free_depth_q != '0) begin
          // reuse the most recently freed slot
          free_depth_d       = free_depth_q - CntW'(1);
          slot_we            = 1'b1;
          slot_waddr         = pop_idx;
          slot_wdata         = {1'b1, pop_gen};
          live_total_d       = live_total_q + CntW'(1);
          rsp.ok             = 1'b1;
          rsp.out_slot       = SLOT_W'(CntW'(pop_idx) + CntW'(1));
          rsp.out_generation = pop_gen;
        end else if (high_water_q < SlotsC) begin
          // append a fresh slot at generation one
          high_water_d       = high_water_q + CntW'(1);
          slot_we            = 1'b1;
          slot_waddr         = IdxW'(high_water_q);
          slot_wdata         = {1'b1, GEN_W'(1)};
          live_total_d       = live_total_q + CntW'(1);
          rsp.ok             = 1'b1;
          rsp.out_slot       = SLOT_W'(high_water_q + CntW'(1));
          rsp.out_generation = GEN_W'(1);
        end else begin
          rsp.status = STATUS_EXHAUSTED;
        end
      end
      MODE_FREE: begin
        if (handle_ok) begin
          slot_we    = 1'b1;
          slot_waddr = IdxW'(hidx_ext);
          slot_wdata = {1'b0, gen_next};
          if (free_depth_q < SlotsC) begin
            stk_we       = 1'b1;
            stk_waddr    = IdxW'(free_depth_q);
            stk_wdata    = {IdxW'(hidx_ext), gen_next};
            free_depth_d = free_depth_q + CntW'(1);
          end
          if (live_total_q != '0) begin
            live_total_d = live_total_q - CntW'(1);
          end
          rsp.ok = 1'b1;
        end else begin
          rsp.status = STATUS_BAD_HANDLE;
        end
      end
      MODE_CHECK: begin
        if (handle_ok) begin
          rsp.ok = 1'b1;
        end else begin
          rsp.status = STATUS_BAD_HANDLE;
        end
      end
      MODE_CLEAR: begin
        // drop every slot; stale table entries sit above the high-water mark
        free_depth_d = '0;
        high_water_d = '0;
        live_total_d = '0;
        rsp.ok       = 1'b1;
      end
      default: begin
        rsp.status = STATUS_BAD_HANDLE;
      end
    endcase

    rsp.live_count = SLOT_W'(live_total_d);

    // commit nothing until the output register can take the item
    if (!exec_done) begin
      free_depth_d = free_depth_q;
      high_water_d = high_water_q;
      live_total_d = live_total_q;
      slot_we      = 1'b0;
      stk_we       = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d   = in_item_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (exec_done) begin
      out_valid_d = 1'b1;
      out_item_d  = rsp;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      free_depth_q <= '0;
      high_water_q <= '0;
      live_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_depth_q <= free_depth_d;
      high_water_q <= high_water_d;
      live_total_q <= live_total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
